/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dimmer core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DMR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dimmer core assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define DMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dimmer core assertion failed");

`endif

/* rtl/core/dmr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimmer core package
// Channel record, command codes and the level step table.
// ---------------------------------------------------------------------------
package dmr_pkg;

	typedef enum logic [2:0] {
		KIND_TICK       = 3'd0,
		KIND_SET_STATUS = 3'd1,
		KIND_SET_PCT    = 3'd2,
		KIND_TOGGLE     = 3'd3,
		KIND_SWEEP_ON   = 3'd4,
		KIND_SWEEP_OFF  = 3'd5,
		KIND_LEVEL_STEP = 3'd6,
		KIND_SET_DELAY  = 3'd7
	} kind_t;

	localparam logic [6:0] LEVEL_FULL = 7'd100;

	typedef struct packed {
		logic       on;
		logic [6:0] cur;
		logic [6:0] tgt;
		logic       sweep;
		logic [7:0] delay;
		logic [7:0] cnt;
		logic [7:0] tmo;
	} rec_t;

	function automatic logic [6:0] next_level(input logic [6:0] t);
		logic [6:0] r;
		case (t)
			7'd1:    r = 7'd2;
			7'd2:    r = 7'd5;
			7'd5:    r = 7'd10;
			7'd10:   r = 7'd20;
			7'd20:   r = 7'd50;
			7'd50:   r = LEVEL_FULL;
			default: r = t;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/dmr_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimmer ring cell
// Holds one channel record and takes its neighbor's record on each shift.
// ---------------------------------------------------------------------------
module dmr_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  dmr_pkg::rec_t d_in,
	output dmr_pkg::rec_t q
);
	import dmr_pkg::*;

	rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= d_in;
		end
	end

	assign q = rec_q;

endmodule

/* rtl/core/dmr_apply.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimmer head update
// Applies a tick or a channel command to the record at the head of the ring.
// ---------------------------------------------------------------------------
module dmr_apply (
	input  dmr_pkg::rec_t  rec,
	input  logic           is_tick,
	input  logic           hit,
	input  dmr_pkg::kind_t kind,
	input  logic [7:0]     value,
	input  logic [7:0]     tmo_default,
	output dmr_pkg::rec_t  nxt,
	output logic           accepted
);
	import dmr_pkg::*;

	always_comb begin
		nxt      = rec;
		accepted = 1'b1;
		if (is_tick) begin
			if (rec.on && (rec.cur != rec.tgt)) begin
				if (rec.cnt >= rec.delay) begin
					nxt.cnt = '0;
					nxt.cur = (rec.cur > rec.tgt) ? rec.cur - 7'd1 : rec.cur + 7'd1;
				end else begin
					nxt.cnt = rec.cnt + 8'd1;
				end
			end
			// The second check sees the target already flipped by the first.
			if (rec.sweep) begin
				if ((nxt.tgt == nxt.cur) && (nxt.tgt == 7'd0)) begin
					nxt.tgt = LEVEL_FULL;
				end
				if ((nxt.tgt == nxt.cur) && (nxt.tgt == LEVEL_FULL)) begin
					nxt.tgt = 7'd0;
				end
			end
		end else if (hit) begin
			case (kind)
				KIND_SET_STATUS: begin
					if (value <= 8'd1) nxt.on = value[0];
					else accepted = 1'b0;
				end
				KIND_SET_PCT: begin
					if (value > 8'd100) begin
						accepted = 1'b0;
					end else if (value == 8'd0) begin
						nxt.on = 1'b0;
					end else begin
						nxt.on  = 1'b1;
						nxt.tgt = value[6:0];
					end
				end
				KIND_TOGGLE:    nxt.on = ~rec.on;
				KIND_SWEEP_ON:  nxt.sweep = 1'b1;
				KIND_SWEEP_OFF: nxt.sweep = 1'b0;
				KIND_LEVEL_STEP: begin
					if (rec.tmo == 8'd0) begin
						if (rec.on) begin
							nxt.on = 1'b0;
						end else begin
							nxt.tmo = tmo_default;
							nxt.on  = 1'b1;
							nxt.tgt = 7'd1;
						end
					end else begin
						nxt.tgt = next_level(rec.tgt);
					end
				end
				KIND_SET_DELAY: nxt.delay = value;
				default:        nxt = rec;
			endcase
		end
	end

endmodule

/* rtl/core/multi_channel_dimmer_ramp_controller_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi-channel dimmer ramp controller core
// Eight-channel light dimmer with ramping, sweep and level stepping.
// ---------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per transfer: tuser is the kind
// (tick or a channel command), tdata holds the channel and the value.
// The master stream returns status reports; tlast marks the final report
// of a command. A command gives one report, a tick one per channel, up to eight.
// Channel records sit in a ring of cells. After a transfer is taken the
// ring rotates once per cycle, save while the output stalls, past a single
// update unit at its head until every record has passed it once; a command
// to a channel that does not exist leaves the ring still and only loads its
// refusal report. Tick reports are offered in channel order.
// The slave side is ready whenever no item is in work, even while a
// report still waits in the output register.
// When the receiver stalls, the ring holds still as soon as the head
// channel needs the occupied output register, and moves on once it drains.
// Reset clears every channel record, the timeout default and the output.
// The timeout default register may be written whenever no item is in work.
// ---------------------------------------------------------------------------
module multi_channel_dimmer_ramp_controller_core #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // channel[2:0], value[10:3], zero fill
	input  logic [2:0]  s_tuser,     // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // out_channel[2:0], light_on[3], level[10:4],
	                                 // target[17:11], sweeping[18], settled[19],
	                                 // accepted[20], zero fill
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);
	import dmr_pkg::*;
	`include "assert_macros.svh"

	localparam int PW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ZW   = PW + 4;
	localparam int NREP = (CHANNELS < 8) ? CHANNELS : 8;

	typedef enum logic {ST_IDLE, ST_BUSY} state_t;

	state_t      state_q;
	logic [PW-1:0] pos_q;
	kind_t       kind_q;
	logic [2:0]  ch_q;
	logic [7:0]  value_q;
	logic        oor_q;
	logic [7:0]  tmo_default_q;
	logic        out_valid_q;
	logic [20:0] out_data_q;
	logic        out_last_q;

	rec_t        ring [CHANNELS];
	rec_t        head_nxt;
	logic        head_acc;
	logic        is_tick;
	logic        hit;
	logic        emit;
	logic        slot_free;
	logic        shift;
	logic        busy;
	logic        at_end;
	logic        in_xfer;
	logic        oor_in;
	logic        load_out;

	assign busy      = (state_q == ST_BUSY);
	assign is_tick   = (kind_q == KIND_TICK);
	assign hit       = !is_tick && (ZW'(pos_q) == ZW'(ch_q));
	assign emit      = is_tick ? (ZW'(pos_q) < ZW'(NREP)) : hit;
	assign slot_free = !out_valid_q || m_tready;
	assign shift     = busy && !oor_q && (!emit || slot_free);
	assign at_end    = (ZW'(pos_q) == ZW'(CHANNELS - 1));
	assign in_xfer   = s_tvalid && s_tready;
	assign oor_in    = (s_tuser != KIND_TICK) && (ZW'(s_tdata[2:0]) >= ZW'(CHANNELS));
	assign load_out  = busy && (oor_q ? slot_free : (shift && emit));

	generate
		for (genvar i = 0; i < CHANNELS; i++) begin : g_ring
			if (i == CHANNELS - 1) begin : g_tail
				dmr_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.d_in   (head_nxt),
					.q      (ring[i])
				);
			end else begin : g_body
				dmr_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.d_in   (ring[i+1]),
					.q      (ring[i])
				);
			end
		end
	endgenerate

	dmr_apply u_apply (
		.rec         (ring[0]),
		.is_tick     (is_tick),
		.hit         (hit),
		.kind        (kind_q),
		.value       (value_q),
		.tmo_default (tmo_default_q),
		.nxt         (head_nxt),
		.accepted    (head_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo_default_q <= '0;
		end else if (cfg_wr_en) begin
			tmo_default_q <= cfg_wr_data;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			kind_q      <= KIND_TICK;
			ch_q        <= '0;
			value_q     <= '0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q  <= kind_t'(s_tuser);
						ch_q    <= s_tdata[2:0];
						value_q <= s_tdata[10:3];
						oor_q   <= oor_in;
						pos_q   <= '0;
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (oor_q) begin
						// A channel that does not exist reports zeros and is refused.
						if (slot_free) begin
							out_data_q  <= {1'b0, 17'd0, ch_q};
							out_last_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else if (shift) begin
						if (emit) begin
							out_data_q  <= {(is_tick ? 1'b1 : head_acc),
								(head_nxt.cur == head_nxt.tgt), head_nxt.sweep,
								head_nxt.tgt, head_nxt.cur, head_nxt.on,
								(is_tick ? 3'(pos_q) : ch_q)};
							out_last_q  <= is_tick ? (ZW'(pos_q) == ZW'(NREP - 1)) : 1'b1;
						end
						if (at_end) begin
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + PW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = !busy;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_data_q};
	assign m_tlast  = out_last_q;

	`DMR_ASSERT(a_accept_at_home, clk, arst_n, !in_xfer || (pos_q == '0))
	`DMR_ASSERT(a_report_from_work, clk, arst_n, !$rose(out_valid_q) || $past(busy))
	`DMR_ASSERT_NEXT(a_stall_holds_ring, clk, arst_n,
		busy && !oor_q && emit && out_valid_q && !m_tready, $stable(pos_q) && busy)
	`DMR_ASSERT_NEXT(a_round_ends, clk, arst_n, shift && at_end, !busy)

endmodule
